// ===== hw/rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator package
// Shared types, constants and arithmetic helpers of the B-spline evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int MAX_POINTS = 256;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int BANKS      = 4;
    localparam int BANK_AW    = ADDR_W - 2;
    localparam int BANK_DEPTH = MAX_POINTS / BANKS;
    localparam logic [16:0] ONE = 17'd65536;

    typedef enum logic [1:0] {
        REG_DEGREE   = 2'd0,
        REG_COUNT    = 2'd1,
        REG_INV_SPAN = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [17:0] t_wgt;
    typedef logic signed [18:0] t_der;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        logic [1:0]  degree;
        logic [8:0]  count;
        logic [31:0] inv_span;
    } t_cfg;

    // Span geometry leaving the front stages.
    typedef struct packed {
        logic              op;
        logic              bad;
        logic [ADDR_W-1:0] idx;
        t_point            pt;
        logic [16:0]       x;
        logic [16:0]       ix;
        logic [16:0]       x2;
        logic [16:0]       ix2;
        logic [ADDR_W-1:0] base;
    } t_geo;

    // Basis weights and the control points they apply to.
    typedef struct packed {
        logic         bad;
        t_wgt [3:0]   w;
        t_der [3:0]   d;
        t_point [3:0] pt;
    } t_basis;

    // Truncating divide by six for values below 2^19.
    function automatic logic [16:0] div6(input logic [19:0] v);
        logic [37:0] m;
        m = v * 18'd174763;
        return m[36:20];
    endfunction

    // Signed halving that truncates toward zero.
    function automatic logic signed [19:0] half_trunc(input logic signed [20:0] v);
        logic signed [20:0] t;
        t = v + 21'(v[20]);
        return t[20:1];
    endfunction

    function automatic t_coord sat32(input logic signed [48:0] v);
        if (&v[48:31] || ~|v[48:31]) begin
            return v[31:0];
        end
        return v[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

// ===== hw/rtl/uniform_bspline_point_and_velocity.sv =====
// ----------------------------------------------------------------------------
// Uniform B-spline point and velocity evaluator
// Evaluates a uniform B-spline of degree 1 to 3 over a table of 3-D control
// points and returns position and time derivative in signed Q16.16.
//
// Channel   Dir  Handshake                  Payload
// s         in   i_s_tvalid / o_s_tready    tdata: point_index, x, y, z, time
//                                           tuser: op
// m         out  o_m_tvalid / i_m_tready    tdata: pos x,y,z, vel x,y,z
//                                           tuser: bad_setup
// cfg       in   i_cfg_valid / o_cfg_ready  index, data
//
// The datapath is a nine stage pipeline that takes one request per cycle
// while the output is not stalled; an evaluate request passes the stages
// below in order and leaves from the output register.
// Stages: time multiply, clamp and span select, squares, cube plus table
// read, weights, products, sums, velocity multiply, output register.
// The table is four banks of 64 entries so the four rows of a span are read
// in the same cycle. Write requests update the table as they pass the read stage
// and leave the pipeline there, so reads and writes stay in request order.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and a stall loses nothing. Reset (synchronous, active low) clears the
// stage valid bits and loads the default configuration; the table has no reset.
// ----------------------------------------------------------------------------
module uniform_bspline_point_and_velocity
    import bsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // point_index[7:0], coord_x[39:8], coord_y[71:40], coord_z[103:72],
    // sample_time[135:104]
    input  logic [135:0] i_s_tdata,
    // op[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], vel_x[127:96],
    // vel_y[159:128], vel_z[191:160]
    output logic [191:0] o_m_tdata,
    // bad_setup[0]
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int STAGES = 9;

    t_cfg              r_cfg;
    logic [STAGES:1]   r_v;
    logic              r_bad [6:STAGES];
    logic [STAGES:1]   n_en;

    t_point            in_pt;
    t_geo              geo;
    t_point [3:0]      rd;
    t_basis            basis;
    t_point            pos;
    t_point            vel;
    logic              mem_we;

    // Configuration is always accepted; index 3 has no register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degree   <= 2'd3;
            r_cfg.count    <= 9'd4;
            r_cfg.inv_span <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEGREE:   r_cfg.degree   <= i_cfg_data[1:0];
                REG_COUNT:    r_cfg.count    <= i_cfg_data[8:0];
                REG_INV_SPAN: r_cfg.inv_span <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        n_en[STAGES] = !r_v[STAGES] || i_m_tready;
        for (int s = STAGES - 1; s >= 1; s--) begin
            n_en[s] = !r_v[s] || n_en[s + 1];
        end
    end

    assign o_s_tready = n_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 1; s <= STAGES; s++) begin
                if (n_en[s]) begin
                    if (s == 1) begin
                        r_v[s] <= i_s_tvalid;
                    end else if (s == 4) begin
                        // Write requests retire here.
                        r_v[s] <= r_v[3] && (geo.op == OP_EVAL);
                    end else begin
                        r_v[s] <= r_v[s - 1];
                    end
                end
            end
        end
    end

    // Bad-setup flag leaves the weight stage and travels beside the
    // accumulate stages for the output.
    always_ff @(posedge i_clk) begin
        if (n_en[6]) r_bad[6] <= basis.bad;
        for (int s = 7; s <= STAGES; s++) begin
            if (n_en[s]) r_bad[s] <= r_bad[s - 1];
        end
    end

    assign in_pt.x = i_s_tdata[39:8];
    assign in_pt.y = i_s_tdata[71:40];
    assign in_pt.z = i_s_tdata[103:72];

    bsp_front u_front (
        .i_clk  (i_clk),
        .i_en   (n_en[3:1]),
        .i_cfg  (r_cfg),
        .i_op   (i_s_tuser),
        .i_idx  (i_s_tdata[ADDR_W-1:0]),
        .i_pt   (in_pt),
        .i_time (i_s_tdata[135:104]),
        .o_geo  (geo)
    );

    assign mem_we = n_en[4] && r_v[3] && (geo.op == OP_WRITE);

    // Rows base..base+3 fall into the four banks once each.
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [1:0]        off;
        logic [ADDR_W-1:0] row;
        assign off = 2'(b) - geo.base[1:0];
        assign row = geo.base + ADDR_W'(off);
        bsp_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (mem_we && (geo.idx[1:0] == 2'(b))),
            .i_waddr (geo.idx[ADDR_W-1:2]),
            .i_wdata (geo.pt),
            .i_re    (n_en[4]),
            .i_raddr (row[ADDR_W-1:2]),
            .o_rdata (rd[b])
        );
    end

    bsp_basis u_basis (
        .i_clk   (i_clk),
        .i_en    (n_en[5:4]),
        .i_cfg   (r_cfg),
        .i_geo   (geo),
        .i_rd    (rd),
        .o_basis (basis)
    );

    bsp_accum u_accum (
        .i_clk   (i_clk),
        .i_en    (n_en[9:6]),
        .i_cfg   (r_cfg),
        .i_basis (basis),
        .o_pos   (pos),
        .o_vel   (vel)
    );

    assign o_m_tvalid = r_v[STAGES];
    assign o_m_tuser  = r_bad[STAGES];
    assign o_m_tdata  = {vel.z, vel.y, vel.x, pos.z, pos.y, pos.x};

`ifndef SYNTH
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("bad setup result carries nonzero payload");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v))
        else $error("input blocked while a pipeline stage is empty");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && geo.op == OP_EVAL && !geo.bad) |->
        (geo.x <= ONE && geo.x + geo.ix == ONE))
        else $error("span fraction out of range");
`endif

endmodule

// ===== hw/rtl/bsp_ram.sv =====
// ----------------------------------------------------------------------------
// B-spline control point bank
// One bank of the control point table: one write port, one registered read.
// ----------------------------------------------------------------------------
module bsp_ram
    import bsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [BANK_AW-1:0] i_waddr,
    input  t_point             i_wdata,
    input  logic               i_re,
    input  logic [BANK_AW-1:0] i_raddr,
    output t_point             o_rdata
);

    t_point r_mem [BANK_DEPTH];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bsp_front.sv =====
// ----------------------------------------------------------------------------
// B-spline front stages
// Time scaling, parameter clamp, span select and fraction squares.
// ----------------------------------------------------------------------------
module bsp_front
    import bsp_pkg::*;
(
    input  logic              i_clk,
    input  logic [2:0]        i_en,
    input  t_cfg              i_cfg,
    input  logic              i_op,
    input  logic [ADDR_W-1:0] i_idx,
    input  t_point            i_pt,
    input  logic [31:0]       i_time,
    output t_geo              o_geo
);

    logic [63:0]       r1_prod;
    logic              r1_op;
    logic [ADDR_W-1:0] r1_idx;
    t_point            r1_pt;
    t_geo              r2_geo;
    t_geo              r3_geo;

    logic [63:0] n1_prod;
    logic [8:0]  cnt;
    logic [8:0]  span_lim;
    logic [47:0] s_raw;
    logic [47:0] lim;
    logic [24:0] s_clamp;
    logic [24:0] e;
    logic [8:0]  k_raw;
    logic [8:0]  k_hi;
    logic [8:0]  k;
    logic [24:0] x_full;
    t_geo        n2_geo;
    t_geo        n3_geo;
    logic [33:0] sq_x;
    logic [33:0] sq_ix;

    assign n1_prod = i_time * i_cfg.inv_span;

    always_comb begin
        cnt      = (i_cfg.count > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : i_cfg.count;
        span_lim = cnt - 9'(i_cfg.degree);
        s_raw    = r1_prod[63:FRAC_BITS];
        lim      = {23'd0, span_lim, 16'd0};
        s_clamp  = (s_raw > lim) ? lim[24:0] : s_raw[24:0];
        e        = s_clamp + {7'd0, i_cfg.degree, 16'd0};
        k_raw    = e[24:16];
        k_hi     = (k_raw > cnt - 9'd1) ? cnt - 9'd1 : k_raw;
        k        = (k_hi < 9'(i_cfg.degree)) ? 9'(i_cfg.degree) : k_hi;
        x_full   = e - {k, 16'd0};
        n2_geo      = '0;
        n2_geo.op   = r1_op;
        n2_geo.bad  = (i_cfg.degree == 2'd0) || (cnt <= 9'(i_cfg.degree));
        n2_geo.idx  = r1_idx;
        n2_geo.pt   = r1_pt;
        n2_geo.x    = x_full[16:0];
        n2_geo.ix   = ONE - x_full[16:0];
        n2_geo.base = ADDR_W'(k - 9'(i_cfg.degree));
        sq_x  = r2_geo.x * r2_geo.x;
        sq_ix = r2_geo.ix * r2_geo.ix;
        n3_geo     = r2_geo;
        n3_geo.x2  = sq_x[32:16];
        n3_geo.ix2 = sq_ix[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prod <= n1_prod;
            r1_op   <= i_op;
            r1_idx  <= i_idx;
            r1_pt   <= i_pt;
        end
        if (i_en[1]) begin
            r2_geo <= n2_geo;
        end
        if (i_en[2]) begin
            r3_geo <= n3_geo;
        end
    end

    assign o_geo = r3_geo;

endmodule

// ===== hw/rtl/bsp_basis.sv =====
// ----------------------------------------------------------------------------
// B-spline basis stages
// Cubes of the fraction, then position and derivative weights per degree.
// ----------------------------------------------------------------------------
module bsp_basis
    import bsp_pkg::*;
(
    input  logic         i_clk,
    input  logic [1:0]   i_en,
    input  t_cfg         i_cfg,
    input  t_geo         i_geo,
    input  t_point [3:0] i_rd,
    output t_basis       o_basis
);

    logic [16:0] r4_x, r4_ix, r4_x2, r4_ix2, r4_x3, r4_ix3;
    logic [1:0]  r4_base;
    logic        r4_bad;
    t_basis      r5_basis;

    logic [33:0]        cube_x;
    logic [33:0]        cube_ix;
    t_basis             n5;
    logic [19:0]        acc_i;
    logic [19:0]        acc_x;
    logic signed [20:0] d1_raw;
    logic signed [20:0] d2_raw;
    logic [1:0]         sel;

    always_comb begin
        cube_x  = i_geo.x2 * i_geo.x;
        cube_ix = i_geo.ix2 * i_geo.ix;
    end

    always_comb begin
        n5     = '0;
        n5.bad = r4_bad;
        acc_i  = 20'(ONE) + 20'd3 * (20'(r4_ix) + 20'(r4_ix2) - 20'(r4_ix3));
        acc_x  = 20'(ONE) + 20'd3 * (20'(r4_x) + 20'(r4_x2) - 20'(r4_x3));
        d1_raw = 21'sd3 * $signed({4'd0, r4_ix2}) - 21'sd2 * $signed({4'd0, r4_ix})
                 - $signed({4'd0, ONE});
        d2_raw = $signed({4'd0, ONE}) + 21'sd2 * $signed({4'd0, r4_x})
                 - 21'sd3 * $signed({4'd0, r4_x2});
        unique case (i_cfg.degree)
            2'd1: begin
                n5.w[0] = 18'(r4_ix);
                n5.w[1] = 18'(r4_x);
                n5.d[0] = -$signed({2'd0, ONE});
                n5.d[1] = $signed({2'd0, ONE});
            end
            2'd2: begin
                n5.w[0] = 18'(r4_ix2 >> 1);
                n5.w[1] = 18'(ONE >> 1) + 18'(r4_x) - 18'(r4_x2);
                n5.w[2] = 18'(r4_x2 >> 1);
                n5.d[0] = -$signed({2'd0, r4_ix});
                n5.d[1] = $signed({2'd0, ONE}) - 19'sd2 * $signed({2'd0, r4_x});
                n5.d[2] = $signed({2'd0, r4_x});
            end
            2'd3: begin
                n5.w[0] = 18'(div6({3'd0, r4_ix3}));
                n5.w[1] = 18'(div6(acc_i));
                n5.w[2] = 18'(div6(acc_x));
                n5.w[3] = 18'(div6({3'd0, r4_x3}));
                n5.d[0] = -$signed({2'd0, r4_ix2 >> 1});
                n5.d[1] = 19'(half_trunc(d1_raw));
                n5.d[2] = 19'(half_trunc(d2_raw));
                n5.d[3] = $signed({2'd0, r4_x2 >> 1});
            end
            default: begin
                n5.w = '0;
                n5.d = '0;
            end
        endcase
        // Rows past the degree carry zero weight; zero their points as well.
        for (int j = 0; j < 4; j++) begin
            sel = r4_base + 2'(j);
            n5.pt[j] = (j <= int'(i_cfg.degree)) ? i_rd[sel] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_x    <= i_geo.x;
            r4_ix   <= i_geo.ix;
            r4_x2   <= i_geo.x2;
            r4_ix2  <= i_geo.ix2;
            r4_x3   <= cube_x[32:16];
            r4_ix3  <= cube_ix[32:16];
            r4_base <= i_geo.base[1:0];
            r4_bad  <= i_geo.bad;
        end
        if (i_en[1]) begin
            r5_basis <= n5;
        end
    end

    assign o_basis = r5_basis;

endmodule

// ===== hw/rtl/bsp_accum.sv =====
// ----------------------------------------------------------------------------
// B-spline accumulate stages
// Weighted point products, sums with saturation and velocity scaling.
// ----------------------------------------------------------------------------
module bsp_accum
    import bsp_pkg::*;
(
    input  logic        i_clk,
    input  logic [3:0]  i_en,
    input  t_cfg        i_cfg,
    input  t_basis      i_basis,
    output t_point      o_pos,
    output t_point      o_vel
);

    logic signed [49:0] r6_pp [4][3];
    logic signed [50:0] r6_vp [4][3];
    logic               r6_bad;
    t_coord             r7_pos [3];
    t_coord             r7_dv  [3];
    logic               r7_bad;
    t_coord             r8_pos [3];
    logic signed [64:0] r8_vm  [3];
    logic               r8_bad;
    t_point             r9_pos;
    t_point             r9_vel;

    logic signed [52:0] psum [3];
    logic signed [52:0] vsum [3];

    // Coordinate c of a point: 0 is x, 1 is y, 2 is z.
    function automatic t_coord coord_of(input t_point p, input int c);
        return (c == 0) ? p.x : (c == 1) ? p.y : p.z;
    endfunction

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            psum[c] = '0;
            vsum[c] = '0;
            for (int j = 0; j < 4; j++) begin
                psum[c] = psum[c] + 53'(r6_pp[j][c]);
                vsum[c] = vsum[c] + 53'(r6_vp[j][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 4; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r6_pp[j][c] <= $signed(i_basis.w[j]) * coord_of(i_basis.pt[j], c);
                    r6_vp[j][c] <= $signed(i_basis.d[j]) * coord_of(i_basis.pt[j], c);
                end
            end
            r6_bad <= i_basis.bad;
        end
        if (i_en[1]) begin
            for (int c = 0; c < 3; c++) begin
                r7_pos[c] <= sat32(49'(psum[c] >>> FRAC_BITS));
                r7_dv[c]  <= sat32(49'(vsum[c] >>> FRAC_BITS));
            end
            r7_bad <= r6_bad;
        end
        if (i_en[2]) begin
            for (int c = 0; c < 3; c++) begin
                r8_pos[c] <= r7_pos[c];
                r8_vm[c]  <= r7_dv[c] * $signed({1'b0, i_cfg.inv_span});
            end
            r8_bad <= r7_bad;
        end
        if (i_en[3]) begin
            if (r8_bad) begin
                r9_pos <= '0;
                r9_vel <= '0;
            end else begin
                r9_pos.x <= r8_pos[0];
                r9_pos.y <= r8_pos[1];
                r9_pos.z <= r8_pos[2];
                r9_vel.x <= sat32(r8_vm[0][64:16]);
                r9_vel.y <= sat32(r8_vm[1][64:16]);
                r9_vel.z <= sat32(r8_vm[2][64:16]);
            end
        end
    end

    assign o_pos = r9_pos;
    assign o_vel = r9_vel;

endmodule
